@@ rtl/core/sha256_pkg.sv @@
// SHA-256 shared types, constants and round functions.
// Depends on nothing; used by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds     = 64;

	localparam word_t Iv [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos  = 6'd56;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t ssig0(input word_t x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	// Schedule memory port request, from engine to schedule store.
	typedef struct packed {
		logic       we;
		logic [3:0] waddr;
		word_t      wdata;
		logic [3:0] raddr;
	} sched_req_t;

endpackage
`default_nettype wire

@@ rtl/core/sha256_sched_mem.sv @@
// Sixteen-word schedule memory: one write port, one read port, registered read.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha256_sched_mem (
	input  wire                    clk,
	input  sha256_pkg::sched_req_t req,
	output sha256_pkg::word_t      rdata
);
	sha256_pkg::word_t mem [16];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/sha256_engine.sv @@
// Compression engine: walks the 64 rounds over the schedule memory,
// four memory reads per round, and folds the result into the hash words.
// Depends on sha256_pkg and sha256_sched_mem.
`timescale 1ns / 1ps
`default_nettype none
module sha256_engine (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  wire                    init_hash,
	output logic                   busy,
	output logic                   done,
	// Schedule loading port used while idle.
	input  wire                    load_we,
	input  wire  [3:0]             load_addr,
	input  sha256_pkg::word_t      load_data,
	output sha256_pkg::word_t      hash_q [8]
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_R0   = 6'b000010,
		S_R1   = 6'b000100,
		S_R2   = 6'b001000,
		S_R3   = 6'b010000,
		S_FOLD = 6'b100000
	} st_t;

	st_t st_q;
	logic [5:0] rnd_q;
	sha256_pkg::word_t v_q [8];
	sha256_pkg::word_t w16_q, w15_q, wsum_q;
	sha256_pkg::sched_req_t req;
	sha256_pkg::word_t rdata, w_new, t1, t2;

	sha256_sched_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

	// Round i reads W[i-15], W[i-7], W[i-2] and then W[i+1-16] for the next round.
	always_comb begin
		req.we    = load_we;
		req.waddr = load_addr;
		req.wdata = load_data;
		req.raddr = rnd_q[3:0];
		case (st_q)
			S_IDLE: req.raddr = 4'd0;
			S_R0:   req.raddr = rnd_q[3:0] - 4'd15;
			S_R1:   req.raddr = rnd_q[3:0] - 4'd7;
			S_R2:   req.raddr = rnd_q[3:0] - 4'd2;
			S_R3:   req.raddr = rnd_q[3:0] + 4'd1;
			default: req.raddr = 4'd0;
		endcase
		if (rnd_q >= 6'd16) begin
			w_new = wsum_q + sha256_pkg::ssig1(rdata);
		end else begin
			w_new = w16_q;
		end
		if (st_q == S_R3 && rnd_q >= 6'd16) begin
			req.we    = 1'b1;
			req.waddr = rnd_q[3:0];
			req.wdata = w_new;
		end
		t1 = v_q[7] + sha256_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha256_pkg::K[rnd_q] + w_new;
		t2 = sha256_pkg::bsig0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign busy = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			rnd_q <= '0;
			done  <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::Iv[i];
		end else begin
			done <= (st_q == S_FOLD);
			if (init_hash) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::Iv[i];
			end
			case (st_q)
				S_IDLE: begin
					if (start) begin
						rnd_q <= '0;
						st_q  <= S_R0;
					end
				end
				S_R0: st_q <= S_R1;
				S_R1: st_q <= S_R2;
				S_R2: st_q <= S_R3;
				S_R3: begin
					rnd_q <= rnd_q + 6'd1;
					st_q  <= (rnd_q == 6'(sha256_pkg::Rounds - 1)) ? S_FOLD : S_R0;
				end
				S_FOLD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Read data lands in the cycle after its address: capture into the right tap.
	// Build the schedule sum in two steps so the round adds only the last term.
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (start) begin
					for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
				end
			end
			S_R0: w16_q <= rdata;
			S_R1: w15_q <= rdata;
			S_R2: wsum_q <= w16_q + sha256_pkg::ssig0(w15_q) + rdata;
			S_R3: begin
				v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/sha256_byte_stream_hasher.sv @@
// Top level of the SHA-256 byte-stream hasher: byte packing, padding
// sequencer and digest output mux. Depends on sha256_pkg, sha256_engine.
//
//   channel  dir  payload
//   s_axis   in   tdata[7:0]=data_byte, tuser[1:0]={end_of_message, byte_present}
//   m_axis   out  tdata[63:0]=digest_part, tuser[1:0]=part_index, tlast=last_part
//
// A beat that holds a byte without finishing a block leaves the hasher ready for
// the next beat. A byte that fills the block starts a compression: 64 rounds of
// four schedule memory reads (one read per cycle), a fold step and a done strobe.
// A finishing beat then waits for any running compression and, per final block,
// fills the rest of the block with pad, zero and length words and compresses it,
// then four output beats follow. Reset clears control and loads the initial hash.
// s_axis_tready is low while a block compresses, the finishing beat waits, the
// final blocks are filled and compressed, or the digest drains; m_axis stalls
// hold the current part.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire  [1:0]  s_axis_tuser,  // [0] byte_present, [1] end_of_message
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata,  // [63:0] digest_part
	output logic [1:0]  m_axis_tuser,  // [1:0] part_index
	output logic        m_axis_tlast   // last_part
);
	typedef enum logic [5:0] {
		T_IDLE  = 6'b000001,
		T_BLK   = 6'b000010,
		T_PAD   = 6'b000100,
		T_LAST  = 6'b001000,
		T_WAIT  = 6'b010000,
		T_OUT   = 6'b100000
	} top_st_t;

	top_st_t st_q;
	logic [63:0] bits_q, len_q;
	logic [23:0] acc_q;
	logic [3:0] fill_q;
	logic [1:0] part_q;
	logic pend_last_q, fin_q;
	logic start, eng_busy, eng_done, load_we;
	logic [3:0] load_addr;
	sha256_pkg::word_t load_data;
	sha256_pkg::word_t hash [8];
	logic acc_byte, acc_end;
	logic [5:0] pos;
	logic [31:0] pad_word;

	sha256_engine u_eng (
		.clk(clk), .arst_n(arst_n), .start(start),
		.init_hash(st_q == T_OUT && m_axis_tready && part_q == 2'd3),
		.busy(eng_busy), .done(eng_done),
		.load_we(load_we), .load_addr(load_addr), .load_data(load_data),
		.hash_q(hash)
	);

	assign s_axis_tready = (st_q == T_IDLE);
	assign acc_byte = s_axis_tvalid && s_axis_tready && s_axis_tuser[0];
	assign acc_end  = s_axis_tvalid && s_axis_tready && s_axis_tuser[1];
	assign pos = bits_q[8:3];

	// Pad word for the current fill slot: pending bytes, 0x80, zeros.
	always_comb begin
		case (pos[1:0])
			2'd0: pad_word = {sha256_pkg::PadByte, 24'd0};
			2'd1: pad_word = {acc_q[7:0], sha256_pkg::PadByte, 16'd0};
			2'd2: pad_word = {acc_q[15:0], sha256_pkg::PadByte, 8'd0};
			default: pad_word = {acc_q[23:0], sha256_pkg::PadByte};
		endcase
	end

	always_comb begin
		load_we   = 1'b0;
		load_addr = pos[5:2];
		load_data = {acc_q, s_axis_tdata};
		start     = 1'b0;
		case (st_q)
			T_IDLE: begin
				load_we = acc_byte && (pos[1:0] == 2'd3);
				start   = acc_byte && (pos == 6'd63);
			end
			T_PAD: begin
				// Pad word (!fin_q), zeros, length (!pend_last_q).
				load_we   = 1'b1;
				load_addr = fill_q;
				if (fill_q == pos[5:2] && !fin_q) begin
					load_data = pad_word;
				end else if (fill_q == 4'd14 && !pend_last_q) begin
					load_data = len_q[63:32];
				end else if (fill_q == 4'd15 && !pend_last_q) begin
					load_data = len_q[31:0];
				end else begin
					load_data = '0;
				end
				start = (fill_q == 4'd15);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= T_IDLE;
			bits_q        <= '0;
			m_axis_tvalid <= 1'b0;
			part_q        <= '0;
			fill_q        <= '0;
			pend_last_q   <= 1'b0;
			fin_q         <= 1'b0;
		end else begin
			case (st_q)
				T_IDLE: begin
					if (acc_byte) begin
						bits_q <= bits_q + 64'd8;
					end
					if (acc_end) begin
						st_q <= T_WAIT;
					end else if (acc_byte && pos == 6'd63) begin
						st_q <= T_BLK;
					end
				end
				T_BLK: if (eng_done) st_q <= T_IDLE;
				T_WAIT: begin
					// Hold until any block started by this beat has finished.
					if (!eng_busy) begin
						len_q       <= bits_q;
						fill_q      <= pos[5:2];
						fin_q       <= 1'b0;
						pend_last_q <= (pos >= sha256_pkg::LenPos);
						st_q        <= T_PAD;
					end
				end
				T_PAD: begin
					fill_q <= fill_q + 4'd1;
					if (fill_q == 4'd15) st_q <= T_LAST;
				end
				T_LAST: begin
					if (eng_done) begin
						if (pend_last_q) begin
							pend_last_q <= 1'b0;
							fin_q  <= 1'b1;
							fill_q <= '0;
							st_q   <= T_PAD;
						end else begin
							part_q        <= '0;
							m_axis_tvalid <= 1'b1;
							st_q          <= T_OUT;
						end
					end
				end
				T_OUT: begin
					if (m_axis_tready) begin
						part_q <= part_q + 2'd1;
						if (part_q == 2'd3) begin
							m_axis_tvalid <= 1'b0;
							bits_q        <= '0;
							st_q          <= T_IDLE;
						end
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	// Collect the leading bytes of each word.
	always_ff @(posedge clk) begin
		if (acc_byte) begin
			acc_q <= {acc_q[15:0], s_axis_tdata};
		end
	end

	assign m_axis_tuser = part_q;
	assign m_axis_tlast = (part_q == 2'd3);
	always_comb begin
		case (part_q)
			2'd0: m_axis_tdata = {hash[0], hash[1]};
			2'd1: m_axis_tdata = {hash[2], hash[3]};
			2'd2: m_axis_tdata = {hash[4], hash[5]};
			default: m_axis_tdata = {hash[6], hash[7]};
		endcase
	end
endmodule
`default_nettype wire
